// File: design/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

  // Configuration port.
  localparam int CFG_W = 16;
  typedef logic [CFG_W-1:0] cfg_data_t;
  typedef logic [0:0]       cfg_idx_t;

  localparam cfg_idx_t REG_QPERIOD = 1'b0;
  localparam cfg_idx_t REG_ACKTO   = 1'b1;

  localparam cfg_data_t QPERIOD_RST = 16'd25;
  localparam cfg_data_t ACKTO_RST   = 16'd100;

  // Command codes as they arrive on the input channel.
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Bus engine phases.
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_START = 4'd1;
  localparam logic [3:0] PH_STOP  = 4'd2;
  localparam logic [3:0] PH_WBIT  = 4'd3;
  localparam logic [3:0] PH_WREL  = 4'd4;
  localparam logic [3:0] PH_WPOLL = 4'd5;
  localparam logic [3:0] PH_WEND  = 4'd6;
  localparam logic [3:0] PH_RBIT  = 4'd7;
  localparam logic [3:0] PH_RACK  = 4'd8;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] byte_in;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  // Item after the front has classified the command.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data;
    logic       send_ack;
    logic       sda;
  } cmd_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
  } out_item_t;

endpackage

// File: design/i2c_master_bit_engine_core.sv
`timescale 1ns / 1ps
// Channel   Ports                                  Transfer when
// input     in_push, in_full, in_item              in_push high and in_full low
// result    out_pop, out_empty, out_item           out_pop high and out_empty low
// config    cfg_we, cfg_index, cfg_wdata           cfg_we high
//
// Every input item is one tick of the bus timing engine and yields exactly one
// result item. The engine retires one item per cycle while an item is waiting and
// the result queue has room; each item passes through the front queue, the
// combinational engine step and the result queue before its result can be popped.
// Reset is synchronous and active low; both queues come up empty, the lines
// released and the configuration at its reset values.
// Either side may stall on its own: while no result is popped the input side still
// takes up to four transfers, two held in each queue, before in_full rises.

module i2c_master_bit_engine_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  i2cm_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output i2cm_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  i2cm_pkg::cfg_idx_t  cfg_index,
  input  i2cm_pkg::cfg_data_t cfg_wdata
);
  import i2cm_pkg::*;

  // Classified items waiting for the engine.
  cmd_item_t cmd_head;
  logic      cmd_empty;
  logic      cmd_pop;

  // Engine results heading for the result queue.
  out_item_t res_item;
  logic      res_push;
  logic      res_full;

  // The front decodes the command field and buffers items, so the host can
  // keep pushing while the engine waits for room downstream.
  i2cm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .pop     (cmd_pop),
    .empty   (cmd_empty),
    .head    (cmd_head)
  );

  // The engine advances the bus state by one tick for each item it takes. It
  // only moves when an item is waiting and the result queue has room, so no
  // tick is ever lost or repeated.
  i2cm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  // The result queue holds finished results until the consumer pops them.
  i2cm_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .full      (res_full),
    .item      (res_item),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

// File: design/i2cm_front.sv
`timescale 1ns / 1ps

module i2cm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  i2cm_pkg::in_item_t  in_item,
  input  logic                pop,
  output logic                empty,
  output i2cm_pkg::cmd_item_t head
);
  import i2cm_pkg::*;

  cmd_item_t  mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push_ok, pop_ok;
  cmd_item_t  dec;

  // Codes outside the command set behave as no command at all.
  always_comb begin
    dec.data     = in_item.byte_in;
    dec.send_ack = in_item.send_ack;
    dec.sda      = in_item.sda_in;
    unique case (in_item.command)
      CMD_START, CMD_STOP, CMD_WRITE, CMD_READ: dec.cmd = in_item.command;
      default:                                  dec.cmd = CMD_NONE;
    endcase
  end

  assign in_full = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign push_ok = in_push && !in_full;
  assign pop_ok  = pop && !empty;
  assign head    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push_ok ? ~wptr_r : wptr_r;
    rptr_nxt  = pop_ok ? ~rptr_r : rptr_r;
    count_nxt = count_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wptr_r] <= dec;
    end
  end

endmodule

// File: design/i2cm_engine.sv
`timescale 1ns / 1ps

module i2cm_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  i2cm_pkg::cfg_idx_t  cfg_index,
  input  i2cm_pkg::cfg_data_t cfg_wdata,
  input  logic                cmd_empty,
  input  i2cm_pkg::cmd_item_t cmd_head,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output i2cm_pkg::out_item_t res_item
);
  import i2cm_pkg::*;

  cfg_data_t  qper_r, ackto_r;

  logic [3:0] phase_r, phase_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       ackm_r, ackm_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ackf_r, ackf_nxt;
  logic [7:0] last_r, last_nxt;
  logic       done;
  logic       go;
  logic       enter;
  logic [3:0] ent_ph;
  logic [1:0] lv_q, lv_e;
  logic [15:0] qlen;

  function automatic logic [2:0] quarters(input logic [3:0] ph);
    logic [2:0] n;
    unique case (ph)
      PH_START, PH_WBIT, PH_RBIT: n = 3'd4;
      PH_STOP:                    n = 3'd5;
      PH_WREL, PH_WEND:           n = 3'd2;
      PH_RACK:                    n = 3'd6;
      default:                    n = 3'd1;
    endcase
    return n;
  endfunction

  // Line levels set at the start of quarter q of phase ph: {scl, sda}.
  function automatic logic [1:0] levels(input logic [3:0] ph, input logic [15:0] q,
                                        input logic scl, input logic sda,
                                        input logic [7:0] shb, input logic [2:0] bi,
                                        input logic am);
    logic c, d;
    c = scl;
    d = sda;
    unique case (ph)
      PH_START: begin
        if (q == 16'd0) begin
          c = 1'b1;
          d = 1'b1;
        end
        if (q == 16'd2) d = 1'b0;
      end
      PH_STOP: begin
        if (q == 16'd0) begin
          c = 1'b0;
          d = 1'b0;
        end
        if (q == 16'd1) c = 1'b1;
        if (q == 16'd3) d = 1'b1;
      end
      PH_WBIT: begin
        if (q == 16'd0) c = 1'b0;
        if (q == 16'd1) d = shb[3'd7 - bi];
        if (q == 16'd2) c = 1'b1;
      end
      PH_WREL: begin
        if (q == 16'd0) begin
          d = 1'b1;
          c = 1'b0;
        end
      end
      PH_WPOLL: c = 1'b1;
      PH_WEND: begin
        if (q == 16'd0) c = 1'b0;
      end
      PH_RBIT: begin
        if (q == 16'd0) begin
          c = 1'b0;
          d = 1'b1;
        end
        if (q == 16'd2) c = 1'b1;
      end
      PH_RACK: begin
        if (q == 16'd0) c = 1'b0;
        if (q == 16'd1) d = !am;
        if (q == 16'd2) c = 1'b1;
        if (q == 16'd4) c = 1'b0;
      end
      default: ;
    endcase
    return {c, d};
  endfunction

  assign go       = !cmd_empty && !res_full;
  assign cmd_pop  = go;
  assign res_push = go;
  assign qlen     = (qper_r == 16'd0) ? 16'd1 : qper_r;

  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    tick_nxt  = tick_r;
    wait_nxt  = wait_r;
    shift_nxt = shift_r;
    ackm_nxt  = ackm_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ackf_nxt  = ackf_r;
    last_nxt  = last_r;
    done      = 1'b0;
    enter     = 1'b0;
    ent_ph    = PH_IDLE;
    lv_q      = 2'b00;

    if (!go) begin
      // Nothing to do without an item and room for its result.
    end else if (phase_r == PH_IDLE) begin
      unique case (cmd_head.cmd)
        CMD_START: begin
          enter  = 1'b1;
          ent_ph = PH_START;
        end
        CMD_STOP: begin
          enter  = 1'b1;
          ent_ph = PH_STOP;
        end
        CMD_WRITE: begin
          shift_nxt = cmd_head.data;
          bit_nxt   = 3'd0;
          enter     = 1'b1;
          ent_ph    = PH_WBIT;
        end
        CMD_READ: begin
          ackm_nxt  = cmd_head.send_ack;
          shift_nxt = 8'd0;
          bit_nxt   = 3'd0;
          enter     = 1'b1;
          ent_ph    = PH_RBIT;
        end
        default: ;
      endcase
    end else if (phase_r == PH_WPOLL) begin
      if (!cmd_head.sda) begin
        ackf_nxt = 1'b1;
        enter    = 1'b1;
        ent_ph   = PH_WEND;
      end else if (wait_r >= ackto_r) begin
        ackf_nxt = 1'b0;
        enter    = 1'b1;
        ent_ph   = PH_WEND;
      end else begin
        wait_nxt = wait_r + 16'd1;
      end
    end else if (({1'b0, tick_r} + 17'd1) >= {1'b0, qlen}) begin
      tick_nxt = 16'd0;
      if (phase_r == PH_RBIT && wait_r == 16'd2) begin
        shift_nxt = {shift_r[6:0], cmd_head.sda};
      end
      if (({1'b0, wait_r} + 17'd1) < {14'd0, quarters(phase_r)}) begin
        wait_nxt = wait_r + 16'd1;
        lv_q     = levels(phase_r, wait_nxt, scl_r, sda_r, shift_nxt, bit_r, ackm_r);
        scl_nxt  = lv_q[1];
        sda_nxt  = lv_q[0];
      end else begin
        unique case (phase_r)
          PH_WBIT: begin
            enter = 1'b1;
            if (bit_r == 3'd7) begin
              ent_ph = PH_WREL;
            end else begin
              bit_nxt = bit_r + 3'd1;
              ent_ph  = PH_WBIT;
            end
          end
          PH_WREL: begin
            enter  = 1'b1;
            ent_ph = PH_WPOLL;
          end
          PH_RBIT: begin
            enter = 1'b1;
            if (bit_r == 3'd7) begin
              ent_ph = PH_RACK;
            end else begin
              bit_nxt = bit_r + 3'd1;
              ent_ph  = PH_RBIT;
            end
          end
          PH_RACK: begin
            last_nxt  = shift_nxt;
            phase_nxt = PH_IDLE;
            wait_nxt  = 16'd0;
            done      = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE;
            wait_nxt  = 16'd0;
            done      = 1'b1;
          end
        endcase
      end
    end else begin
      tick_nxt = tick_r + 16'd1;
    end

    lv_e = levels(ent_ph, 16'd0, scl_r, sda_r, shift_nxt, bit_nxt, ackm_nxt);
    if (enter) begin
      phase_nxt = ent_ph;
      wait_nxt  = 16'd0;
      tick_nxt  = 16'd0;
      scl_nxt   = lv_e[1];
      sda_nxt   = lv_e[0];
    end
  end

  always_comb begin
    res_item.scl_out   = scl_nxt;
    res_item.sda_out   = sda_nxt;
    res_item.busy_res  = (phase_nxt != PH_IDLE);
    res_item.done_res  = done;
    res_item.read_data = last_nxt;
    res_item.ack_seen  = ackf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qper_r  <= QPERIOD_RST;
      ackto_r <= ACKTO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_QPERIOD: qper_r  <= cfg_wdata;
        REG_ACKTO:   ackto_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bit_r   <= 3'd0;
      tick_r  <= 16'd0;
      wait_r  <= 16'd0;
      shift_r <= 8'd0;
      ackm_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ackf_r  <= 1'b0;
      last_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      tick_r  <= tick_nxt;
      wait_r  <= wait_nxt;
      shift_r <= shift_nxt;
      ackm_r  <= ackm_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ackf_r  <= ackf_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// File: design/i2cm_resq.sv
`timescale 1ns / 1ps

module i2cm_resq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  i2cm_pkg::out_item_t item,
  input  logic                out_pop,
  output logic                out_empty,
  output i2cm_pkg::out_item_t out_item
);
  import i2cm_pkg::*;

  out_item_t  mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push_ok, pop_ok;

  assign full      = (count_r == 2'd2);
  assign out_empty = (count_r == 2'd0);
  assign push_ok   = push && !full;
  assign pop_ok    = out_pop && !out_empty;
  assign out_item  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push_ok ? ~wptr_r : wptr_r;
    rptr_nxt  = pop_ok ? ~rptr_r : rptr_r;
    count_nxt = count_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wptr_r] <= item;
    end
  end

endmodule

// File: design/i2cm_checker.sv
`timescale 1ns / 1ps

module i2cm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input i2cm_pkg::out_item_t out_item
);
  import i2cm_pkg::*;

  // A finishing tick always reports the engine as no longer busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_item.done_res && out_item.busy_res))
    else $error("result shows done and busy together");

  // Reset leaves the result queue empty and the input side not full.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A waiting result that is not popped stays on the ports unchanged.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("waiting result changed or vanished");

endmodule

bind i2c_master_bit_engine_core i2cm_checker u_checker (.*);

// File: dv/i2c_master_bit_engine_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the I2C master bit engine core.
//
// Every input transfer is one tick of the bus timing engine and produces exactly one
// result transfer. The bench keeps its own cycle-accurate model of the engine. Each
// accepted tick is run through that model right away, and the line levels, status bits,
// read byte and ACK flag that it predicts are queued. The monitor compares every popped
// result against the head of that queue, one field at a time.
//
// The stimulus is built as bus commands. Each command tick is followed by enough quiet
// ticks to let the engine finish. The SDA level that the bench presents on those ticks
// follows a per-command pattern: always high (the slave never acknowledges and reads
// return ones), always low, mostly high or random. This makes the ACK poll run into its
// timeout, end on its first sample or end anywhere in between. Some commands are cut
// short on purpose, and stray commands are scattered through the first half of a
// command. That keeps the "command while busy is ignored" path busy.

module i2c_master_bit_engine_core_tb;
  import i2cm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  // Codes above read are not decoded by the engine.
  localparam logic [2:0] CMD_UNUSED_LO = CMD_READ + 3'd1;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  // SDA patterns presented by the simulated slave while a command runs.
  localparam int SDA_RANDOM      = 0;
  localparam int SDA_HIGH        = 1;
  localparam int SDA_LOW         = 2;
  localparam int SDA_MOSTLY_HIGH = 3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_push   = 1'b0;
  logic      in_full;
  in_item_t  in_item   = '0;
  logic      out_empty;
  logic      out_pop   = 1'b0;
  out_item_t out_item;
  logic      cfg_we    = 1'b0;
  cfg_idx_t  cfg_index = REG_QPERIOD;
  cfg_data_t cfg_wdata = '0;

  i2c_master_bit_engine_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ticks waiting to be driven, and the results that accepted ticks must produce.
  in_item_t  pending_ticks[$];
  out_item_t expected_lines[$];

  int mismatches    = 0;
  int idle_cycles   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // -------------------------------------------------------------------------
  // Engine model: the configuration copy and the state as it stands after reset.
  // -------------------------------------------------------------------------
  cfg_data_t   qp_reg    = QPERIOD_RST;
  cfg_data_t   ackto_reg = ACKTO_RST;
  logic [3:0]  m_phase   = PH_IDLE;
  logic [2:0]  m_bit     = '0;
  logic [15:0] m_ticks   = '0;
  logic [15:0] m_quarter = '0;  // Quarter within a phase, or the poll count while polling.
  logic [7:0]  m_shift   = '0;
  logic        m_ackmode = 1'b0;
  logic        m_scl     = 1'b1;
  logic        m_sda     = 1'b1;
  logic        m_ackflag = 1'b0;
  logic [7:0]  m_rdbyte  = '0;
  logic        m_done    = 1'b0;

  function automatic int phase_quarters(logic [3:0] ph);
    case (ph)
      PH_START: return 4;
      PH_STOP:  return 5;
      PH_WBIT:  return 4;
      PH_WREL:  return 2;
      PH_WEND:  return 2;
      PH_RBIT:  return 4;
      PH_RACK:  return 6;
      default:  return 1;
    endcase
  endfunction

  // Line levels change only on quarter boundaries. The ACK poll is the exception:
  // there SCL is simply held high.
  function automatic void set_lines();
    case (m_phase)
      PH_START: begin
        if (m_quarter == 0) begin
          m_scl = 1'b1;
          m_sda = 1'b1;
        end
        if (m_quarter == 2) m_sda = 1'b0;
      end
      PH_STOP: begin
        // SDA goes low first, so that raising SCL can never look like a start.
        if (m_quarter == 0) begin
          m_scl = 1'b0;
          m_sda = 1'b0;
        end
        if (m_quarter == 1) m_scl = 1'b1;
        if (m_quarter == 3) m_sda = 1'b1;
      end
      PH_WBIT: begin
        if (m_quarter == 0) m_scl = 1'b0;
        if (m_quarter == 1) m_sda = m_shift[3'd7 - m_bit];
        if (m_quarter == 2) m_scl = 1'b1;
      end
      PH_WREL: begin
        if (m_quarter == 0) begin
          m_sda = 1'b1;
          m_scl = 1'b0;
        end
      end
      PH_WPOLL: m_scl = 1'b1;
      PH_WEND: begin
        if (m_quarter == 0) m_scl = 1'b0;
      end
      PH_RBIT: begin
        if (m_quarter == 0) begin
          m_scl = 1'b0;
          m_sda = 1'b1;
        end
        if (m_quarter == 2) m_scl = 1'b1;
      end
      PH_RACK: begin
        if (m_quarter == 0) m_scl = 1'b0;
        if (m_quarter == 1) m_sda = !m_ackmode;
        if (m_quarter == 2) m_scl = 1'b1;
        if (m_quarter == 4) m_scl = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void enter_phase(logic [3:0] ph);
    m_phase   = ph;
    m_quarter = '0;
    m_ticks   = '0;
    set_lines();
  endfunction

  function automatic void go_idle();
    m_phase   = PH_IDLE;
    m_quarter = '0;
    m_ticks   = '0;
    m_done    = 1'b1;
  endfunction

  function automatic void close_quarter(logic sda);
    // A read bit is sampled at the end of the first SCL-high quarter.
    if (m_phase == PH_RBIT && m_quarter == 2) m_shift = {m_shift[6:0], sda};
    if (m_quarter + 1 < phase_quarters(m_phase)) begin
      m_quarter = m_quarter + 16'd1;
      set_lines();
    end else begin
      case (m_phase)
        PH_WBIT: begin
          if (m_bit == 3'd7) begin
            enter_phase(PH_WREL);
          end else begin
            m_bit = m_bit + 3'd1;
            enter_phase(PH_WBIT);
          end
        end
        PH_WREL: enter_phase(PH_WPOLL);
        PH_RBIT: begin
          if (m_bit == 3'd7) begin
            enter_phase(PH_RACK);
          end else begin
            m_bit = m_bit + 3'd1;
            enter_phase(PH_RBIT);
          end
        end
        PH_RACK: begin
          m_rdbyte = m_shift;
          go_idle();
        end
        default: go_idle();
      endcase
    end
  endfunction

  // Advances the model by one tick and returns the result that this tick produces.
  function automatic out_item_t engine_tick(in_item_t t);
    logic [16:0] qlen;
    out_item_t   r;
    // A zero quarter period behaves as a single tick.
    qlen   = (qp_reg == '0) ? 17'd1 : {1'b0, qp_reg};
    m_done = 1'b0;
    if (m_phase == PH_IDLE) begin
      // New commands are decoded only here; while busy they are dropped.
      case (t.command)
        CMD_START: enter_phase(PH_START);
        CMD_STOP:  enter_phase(PH_STOP);
        CMD_WRITE: begin
          m_shift = t.byte_in;
          m_bit   = '0;
          enter_phase(PH_WBIT);
        end
        CMD_READ: begin
          m_ackmode = t.send_ack;
          m_shift   = '0;
          m_bit     = '0;
          enter_phase(PH_RBIT);
        end
        default: ;
      endcase
    end else if (m_phase == PH_WPOLL) begin
      if (!t.sda_in) begin
        m_ackflag = 1'b1;
        enter_phase(PH_WEND);
      end else if (m_quarter >= ackto_reg) begin
        m_ackflag = 1'b0;
        enter_phase(PH_WEND);
      end else begin
        m_quarter = m_quarter + 16'd1;
      end
    end else if ({1'b0, m_ticks} + 17'd1 >= qlen) begin
      m_ticks = '0;
      close_quarter(t.sda_in);
    end else begin
      m_ticks = m_ticks + 16'd1;
    end
    r.scl_out   = m_scl;
    r.sda_out   = m_sda;
    r.busy_res  = (m_phase != PH_IDLE);
    r.done_res  = m_done;
    r.read_data = m_rdbyte;
    r.ack_seen  = m_ackflag;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Driver. The tick on the input port is held until it transfers. The model
  // consumes it at that same edge, and the next tick is then loaded, unless the
  // sender idles for this cycle.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_push && !in_full) begin
        expected_lines.push_back(engine_tick(in_item));
      end
      if (!in_push || !in_full) begin
        if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_push <= 1'b1;
          in_item <= pending_ticks.pop_front();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor and watchdog. The watchdog measures the cycles in which neither
  // channel completes a transfer.
  // -------------------------------------------------------------------------
  task automatic check_field(string field, int want_v, int got_v);
    if (want_v != got_v) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result transfer with nothing expected", $time);
        end else begin
          want = expected_lines.pop_front();
          check_field("scl_out", want.scl_out, out_item.scl_out);
          check_field("sda_out", want.sda_out, out_item.sda_out);
          check_field("busy_res", want.busy_res, out_item.busy_res);
          check_field("done_res", want.done_res, out_item.done_res);
          check_field("read_data", want.read_data, out_item.read_data);
          check_field("ack_seen", want.ack_seen, out_item.ack_seen);
        end
      end
      out_pop <= ($urandom_range(99) >= recv_idle_pct);

      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus.
  // -------------------------------------------------------------------------

  // Upper bound on the ticks that a command occupies under the current settings.
  // For a write, this assumes the ACK poll runs to its full timeout.
  function automatic int command_ticks(logic [2:0] cmd);
    int q;
    q = (qp_reg == '0) ? 1 : int'(qp_reg);
    case (cmd)
      CMD_START: return 4 * q;
      CMD_STOP:  return 5 * q;
      CMD_WRITE: return 36 * q + int'(ackto_reg) + 1;
      CMD_READ:  return 38 * q;
      default:   return 1;
    endcase
  endfunction

  function automatic in_item_t make_tick(logic [2:0] cmd, int sda_style);
    in_item_t t;
    t.command  = cmd;
    t.byte_in  = 8'($urandom);
    t.send_ack = 1'($urandom);
    case (sda_style)
      SDA_HIGH:        t.sda_in = 1'b1;
      SDA_LOW:         t.sda_in = 1'b0;
      SDA_MOSTLY_HIGH: t.sda_in = ($urandom_range(5) != 0);
      default:         t.sda_in = 1'($urandom);
    endcase
    return t;
  endfunction

  // Queues one command tick followed by quiet ticks. When noisy is set, stray
  // commands land in the first half of the span, where the engine is still busy.
  task automatic queue_command(logic [2:0] cmd, logic [7:0] data, logic ack,
                               int sda_style, int span, bit noisy);
    in_item_t t;
    logic [2:0] filler;
    t          = make_tick(cmd, sda_style);
    t.byte_in  = data;
    t.send_ack = ack;
    pending_ticks.push_back(t);
    for (int i = 1; i < span; i++) begin
      filler = CMD_NONE;
      if (noisy && i < span / 2 && $urandom_range(7) == 0) filler = 3'($urandom);
      pending_ticks.push_back(make_tick(filler, sda_style));
    end
  endtask

  task automatic queue_full(logic [2:0] cmd, logic [7:0] data, logic ack, int sda_style);
    queue_command(cmd, data, ack, sda_style, command_ticks(cmd) + 1, 1'b0);
  endtask

  task automatic random_traffic(int tick_budget);
    int used;
    int pick;
    int span;
    logic [2:0] cmd;
    used = 0;
    while (used < tick_budget) begin
      pick = $urandom_range(9);
      if (pick < 2) cmd = CMD_START;
      else if (pick < 4) cmd = CMD_STOP;
      else if (pick < 7) cmd = CMD_WRITE;
      else if (pick < 9) cmd = CMD_READ;
      else cmd = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      span = command_ticks(cmd) + $urandom_range(3);
      // Now and then the next command follows too early and is dropped by the engine.
      if ($urandom_range(7) == 0) span = $urandom_range(span, 1);
      queue_command(cmd, 8'($urandom), 1'($urandom), $urandom_range(3), span, 1'b1);
      used += span;
    end
  endtask

  // Waits until every queued tick has transferred and every result has been checked.
  // The extra cycles cover the engine pipeline before the configuration may change.
  task automatic wait_drained();
    do @(negedge clk); while (pending_ticks.size() != 0 || in_push || expected_lines.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_QPERIOD) qp_reg = val;
    else ackto_reg = val;
  endtask

  task automatic reconfigure(cfg_data_t qp, cfg_data_t ackto);
    wait_drained();
    write_reg(REG_QPERIOD, qp);
    write_reg(REG_ACKTO, ackto);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // First third: the sender idles lightly, and the receiver stalls most of the time.
    send_idle_pct = 22;
    recv_idle_pct = 84;

    // One start at the reset timing checks the default quarter period.
    queue_full(CMD_START, 8'h00, 1'b0, SDA_RANDOM);

    // A zero quarter period acts as one tick, and a zero timeout allows a single ACK sample.
    reconfigure(16'd0, 16'd0);
    queue_command(CMD_UNUSED_LO, 8'hFF, 1'b1, SDA_RANDOM, 1, 1'b0);
    queue_command(CMD_UNUSED_LO + 3'd1, 8'h00, 1'b0, SDA_RANDOM, 1, 1'b0);
    queue_command(CMD_UNUSED_HI, 8'hFF, 1'b1, SDA_RANDOM, 1, 1'b0);
    queue_full(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
    queue_full(CMD_WRITE, 8'hFF, 1'b0, SDA_HIGH);     // The slave never acknowledges.
    queue_full(CMD_START, 8'h00, 1'b0, SDA_RANDOM);   // Repeated start while SCL is low.
    queue_full(CMD_WRITE, 8'h00, 1'b1, SDA_LOW);      // Acknowledged on the first sample.
    queue_full(CMD_READ, 8'h00, 1'b1, SDA_HIGH);      // All ones, then ACK.
    queue_full(CMD_READ, 8'hFF, 1'b0, SDA_LOW);       // All zeros, then NACK.
    // A write that arrives while a start is in progress is dropped.
    queue_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 2, 1'b0);
    queue_command(CMD_WRITE, 8'hA5, 1'b1, SDA_LOW, command_ticks(CMD_START), 1'b0);
    queue_full(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);

    reconfigure(16'd1, 16'd5);
    random_traffic(30);

    // Second third: the sender idles often, and the receiver rarely stalls.
    wait_drained();
    send_idle_pct = 84;
    recv_idle_pct = 22;
    reconfigure(16'd1, 16'd2);
    random_traffic(30);

    // Last third: neither side idles. The largest quarter period and the longest ACK
    // timeout run here.
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // The start is cut short inside its first quarter and finishes under the next setting.
    reconfigure(16'hFFFF, 16'd0);
    queue_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 6, 1'b1);
    reconfigure(16'd1, 16'hFFFF);
    queue_command(CMD_NONE, 8'h00, 1'b0, SDA_RANDOM, 4, 1'b0);
    // With the longest timeout the ACK poll ends only on a low sample.
    queue_command(CMD_WRITE, 8'h3C, 1'b0, SDA_MOSTLY_HIGH, 60, 1'b0);
    reconfigure(16'd1, 16'd3);
    random_traffic(30);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
